>>> rtl/tensor_bezier_patch_evaluator_unit_defines.svh
// assertion macros for the bezier patch evaluator
// no dependencies
`ifndef TENSOR_BEZIER_PATCH_EVALUATOR_UNIT_DEFINES_SVH
`define TENSOR_BEZIER_PATCH_EVALUATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TBP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TBP_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TBP_ASSERT(lbl, clk, rst, prop, msg)
`define TBP_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/tbpe_pkg.sv
// shared constants and types for the bezier patch evaluator
// no dependencies
package tbpe_pkg;
  localparam int MaxDims       = 3;
  localparam int MaxDegree     = 3;
  localparam int MaxComponents = 4;
  localparam int StoreDepth    = 256;
  localparam int StoreAw       = 8;
  localparam int WorkDepth     = 64;
  localparam int WorkAw        = 6;
  localparam int ScrDepth      = 16;
  localparam int ScrAw         = 4;
  localparam logic [16:0] OneQ16 = 17'h10000;

  localparam logic [2:0] RegDims  = 3'd0;
  localparam logic [2:0] RegComps = 3'd1;
  localparam logic [2:0] RegDeg0  = 3'd2;
  localparam logic [2:0] RegDeg1  = 3'd3;
  localparam logic [2:0] RegDeg2  = 3'd4;

  localparam logic FuncWrite = 1'b0;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOAD  = 10'b0000000010,
    S_AXIS  = 10'b0000000100,
    S_GRP   = 10'b0000001000,
    S_FILL  = 10'b0000010000,
    S_LERPA = 10'b0000100000,
    S_LERPB = 10'b0001000000,
    S_LERPC = 10'b0010000000,
    S_STORE = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;
endpackage

>>> rtl/tbpe_ram.sv
// generic single-port-write, registered-read ram, write-through on a same-address read
// no dependencies
module tbpe_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // a read of the address being written returns the new word
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/tensor_bezier_patch_evaluator_unit.sv
// Tensor-product Bezier patch evaluator
// The block takes transactions on the s_axis group. tuser is func:
// 0 writes one Q16.16 coefficient (tdata bits 7:0 index, 39:8 value),
// 1 evaluates the patch at three Q1.16 parameters (tdata bits 56:40,
// 73:57, 90:74). An evaluation gives one result per component in use
// (components_in_use clamped to at least 1 and at most CmpCap) on
// m_axis; tdata holds point_value and component_index, tlast marks the final coordinate.
// Config registers (cfg_valid/cfg_ready, cfg_index, cfg_data): dims,
// components, degree of axes 0..2; reset values all 1.
// An evaluation runs per component: copy of the control net into a
// working ram, an S_AXIS setup state per axis, then per group the row
// is fetched into a scratch ram, reduced by g*(g+1)/2 lerps (states
// LERPA, LERPB, LERPC each) on the one shared multiply unit, and stored
// back; the result is then read (S_GRP) and presented (S_OUT). The
// lerp unit sets the pace. s_axis tready is low during the work.
// Each result waits in an output register; while the receiver stalls
// the sequencer holds before the next result. Reset is synchronous and
// clears control state; the coefficient store is undefined until written.
`include "tensor_bezier_patch_evaluator_unit_defines.svh"
module tensor_bezier_patch_evaluator_unit #(
  parameter int MAX_DIMS       = tbpe_pkg::MaxDims,
  parameter int MAX_DEGREE     = tbpe_pkg::MaxDegree,
  parameter int MAX_COMPONENTS = tbpe_pkg::MaxComponents
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // coeff_index[7:0], coeff_value[39:8], param_x0[56:40],
  // param_x1[73:57], param_x2[90:74], zero pad to 96
  input  logic [95:0] s_axis_tdata,
  // func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // point_value[31:0], component_index[33:32], zero pad to 40
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  localparam logic [1:0] DimCap = (MAX_DIMS < 3) ? 2'(MAX_DIMS) : 2'd3;
  localparam logic [1:0] DegCap = (MAX_DEGREE < 3) ? 2'(MAX_DEGREE) : 2'd3;
  localparam logic [2:0] CmpCap = (MAX_COMPONENTS < 4) ? 3'(MAX_COMPONENTS) : 3'd4;

  // configuration
  logic [1:0] dims_in_use;
  logic [2:0] components_in_use;
  logic [1:0] deg [3];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= 2'd1;
      components_in_use <= 3'd1;
      deg[0] <= 2'd1;
      deg[1] <= 2'd1;
      deg[2] <= 2'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbpe_pkg::RegDims:  dims_in_use <= cfg_data[1:0];
        tbpe_pkg::RegComps: components_in_use <= cfg_data;
        tbpe_pkg::RegDeg0:  deg[0] <= cfg_data[1:0];
        tbpe_pkg::RegDeg1:  deg[1] <= cfg_data[1:0];
        tbpe_pkg::RegDeg2:  deg[2] <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  tbpe_pkg::state_t state;
  logic [1:0]  m;        // clamped dims
  logic [2:0]  n;        // clamped components
  logic [1:0]  g [3];
  logic [16:0] x [3];
  logic [1:0]  comp;
  logic [1:0]  axis;     // current axis
  logic [6:0]  cnt;      // points in working net
  logic [6:0]  ld_i;     // load counter
  logic [6:0]  grp;      // group index
  logic [5:0]  grp_base; // group start in work net
  logic [2:0]  fill_i;
  logic [2:0]  r;        // reduction round
  logic [2:0]  s;        // position in round
  logic [31:0] lerp_a;
  logic [31:0] out_val;
  logic [1:0]  out_comp;
  logic        out_last;
  logic        rd_pending;

  // clamped config, captured into m and n when an evaluation is accepted
  logic [1:0] m_c;
  logic [2:0] n_c;
  always_comb begin
    m_c = (dims_in_use > DimCap) ? DimCap : dims_in_use;
    if (components_in_use == 3'd0) n_c = 3'd1;
    else if (components_in_use > CmpCap) n_c = CmpCap;
    else n_c = components_in_use;
  end

  logic s_acc;
  assign s_axis_tready = (state == tbpe_pkg::S_IDLE);
  assign s_acc = s_axis_tvalid & s_axis_tready;

  // control store
  logic                         st_we;
  logic [tbpe_pkg::StoreAw-1:0] st_raddr;
  logic [31:0]                  st_rdata;
  logic [7:0]                   ld_addr;
  assign st_we = s_acc && (s_axis_tuser == tbpe_pkg::FuncWrite);
  tbpe_ram #(.Width(32), .Depth(tbpe_pkg::StoreDepth)) u_store (
    .clk(clk), .we(st_we), .waddr(s_axis_tdata[7:0]),
    .wdata(s_axis_tdata[39:8]), .raddr(st_raddr), .rdata(st_rdata));

  // ld_i*n + comp, wraps modulo 256
  assign ld_addr = 8'(ld_i) * 8'(n) + 8'(comp);
  assign st_raddr = ld_addr;

  // working net
  logic                        wk_we;
  logic [tbpe_pkg::WorkAw-1:0] wk_waddr, wk_raddr;
  logic [31:0]                 wk_wdata, wk_rdata;
  tbpe_ram #(.Width(32), .Depth(tbpe_pkg::WorkDepth)) u_work (
    .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(wk_rdata));

  // scratch row
  logic                       sc_we;
  logic [tbpe_pkg::ScrAw-1:0] sc_waddr, sc_raddr;
  logic [31:0]                sc_wdata, sc_rdata;
  tbpe_ram #(.Width(32), .Depth(tbpe_pkg::ScrDepth)) u_scr (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rdata));

  // shared lerp unit: a + x*(b-a) computed as (1-x)*a + x*b, floor >>16
  logic [16:0] xa;
  logic [2:0]  len;
  logic signed [49:0] lerp_prod;
  logic [31:0] lerp_res;
  assign xa = x[axis];
  assign len = 3'(g[axis]) + 3'd1;
  always_ff @(posedge clk) begin
    lerp_prod <= $signed({1'b0, 17'(tbpe_pkg::OneQ16 - xa)}) * $signed(lerp_a)
               + $signed({1'b0, xa}) * $signed(sc_rdata);
  end
  assign lerp_res = lerp_prod[47:16];

  // group count after reducing the current axis
  logic [6:0] groups;
  always_comb begin
    case (len)
      3'd1: groups = cnt;
      3'd2: groups = {1'b0, cnt[6:1]};
      3'd3: groups = 7'((14'(cnt) * 14'd43) >> 7);
      default: groups = {2'b0, cnt[6:2]};
    endcase
  end

  logic [6:0] net_size;
  always_comb begin
    net_size = 7'd1;
    if (m > 2'd0) net_size = 7'(g[0]) + 7'd1;
    if (m > 2'd1) net_size = 7'(net_size * (7'(g[1]) + 7'd1));
    if (m > 2'd2) net_size = 7'(net_size * (7'(g[2]) + 7'd1));
  end

  always_comb begin
    wk_we = 1'b0; wk_waddr = ld_i[5:0] - 6'd1; wk_wdata = st_rdata;
    wk_raddr = grp_base + 6'(fill_i);
    sc_we = 1'b0; sc_waddr = 4'(fill_i) - 4'd1; sc_wdata = wk_rdata;
    sc_raddr = 4'(s);
    case (state)
      tbpe_pkg::S_LOAD: wk_we = rd_pending;
      // row word 0 is read while the fill ends, ready for the first lerp
      tbpe_pkg::S_FILL: begin
        sc_we = rd_pending; sc_raddr = 4'd0;
      end
      tbpe_pkg::S_LERPA: sc_raddr = 4'(s) + 4'd1;
      // fetch a of the next lerp, or word 0 at the end of a round
      tbpe_pkg::S_LERPC: begin
        sc_we = 1'b1; sc_waddr = 4'(s); sc_wdata = lerp_res;
        sc_raddr = (s + 3'd1 == r) ? 4'd0 : 4'(s) + 4'd1;
      end
      tbpe_pkg::S_STORE: begin
        wk_we = 1'b1; wk_waddr = grp[5:0]; wk_wdata = sc_rdata;
      end
      tbpe_pkg::S_GRP: wk_raddr = 6'd0;
      tbpe_pkg::S_OUT: wk_raddr = 6'd0;
      default: ;
    endcase
  end

  // result valid: set when a result is loaded, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == tbpe_pkg::S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbpe_pkg::S_IDLE;
      rd_pending <= 1'b0;
    end else begin
      case (state)
        tbpe_pkg::S_IDLE: if (s_acc && s_axis_tuser != tbpe_pkg::FuncWrite) begin
          m <= m_c; n <= n_c;
          for (int i = 0; i < 3; i++) g[i] <= (deg[i] > DegCap) ? DegCap : deg[i];
          x[0] <= (s_axis_tdata[56:40] > tbpe_pkg::OneQ16) ? tbpe_pkg::OneQ16
                                                          : s_axis_tdata[56:40];
          x[1] <= (s_axis_tdata[73:57] > tbpe_pkg::OneQ16) ? tbpe_pkg::OneQ16
                                                          : s_axis_tdata[73:57];
          x[2] <= (s_axis_tdata[90:74] > tbpe_pkg::OneQ16) ? tbpe_pkg::OneQ16
                                                          : s_axis_tdata[90:74];
          comp <= 2'd0; ld_i <= 7'd0; rd_pending <= 1'b0;
          state <= tbpe_pkg::S_LOAD;
        end
        tbpe_pkg::S_LOAD: begin
          // read address ld_i issued this cycle, data written next
          if (ld_i == net_size) begin
            rd_pending <= 1'b0; cnt <= net_size;
            axis <= m - 2'd1;
            state <= (m == 2'd0) ? tbpe_pkg::S_GRP : tbpe_pkg::S_AXIS;
            grp <= 7'd0;
          end else begin
            rd_pending <= 1'b1; ld_i <= ld_i + 7'd1;
          end
        end
        tbpe_pkg::S_AXIS: begin
          grp <= 7'd0; grp_base <= 6'd0; fill_i <= 3'd0; rd_pending <= 1'b0;
          state <= tbpe_pkg::S_FILL;
        end
        tbpe_pkg::S_FILL: begin
          if (fill_i == len) begin
            rd_pending <= 1'b0; r <= 3'(g[axis]); s <= 3'd0;
            state <= (g[axis] == 2'd0) ? tbpe_pkg::S_STORE : tbpe_pkg::S_LERPA;
          end else begin
            rd_pending <= 1'b1; fill_i <= fill_i + 3'd1;
          end
        end
        tbpe_pkg::S_LERPA: begin
          // scratch read of s issued previously holds a; read s+1 now
          lerp_a <= sc_rdata; state <= tbpe_pkg::S_LERPB;
        end
        tbpe_pkg::S_LERPB: state <= tbpe_pkg::S_LERPC;
        tbpe_pkg::S_LERPC: begin
          if (s + 3'd1 == r) begin
            s <= 3'd0; r <= r - 3'd1;
            state <= (r == 3'd1) ? tbpe_pkg::S_STORE : tbpe_pkg::S_LERPA;
          end else begin
            s <= s + 3'd1; state <= tbpe_pkg::S_LERPA;
          end
        end
        tbpe_pkg::S_STORE: begin
          if (grp + 7'd1 == groups) begin
            cnt <= groups;
            if (axis == 2'd0) begin
              grp <= 7'd0; state <= tbpe_pkg::S_GRP;
            end else begin
              axis <= axis - 2'd1; state <= tbpe_pkg::S_AXIS;
            end
          end else begin
            grp <= grp + 7'd1; grp_base <= grp_base + 6'(len);
            fill_i <= 3'd0; state <= tbpe_pkg::S_FILL;
          end
        end
        tbpe_pkg::S_GRP: state <= tbpe_pkg::S_OUT; // read word 0 of net
        tbpe_pkg::S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          out_val <= wk_rdata; out_comp <= comp;
          out_last <= (3'(comp) + 3'd1 == n);
          if (3'(comp) + 3'd1 == n) begin
            state <= tbpe_pkg::S_IDLE;
          end else begin
            comp <= comp + 2'd1; ld_i <= 7'd0; state <= tbpe_pkg::S_LOAD;
          end
        end
        default: state <= tbpe_pkg::S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {6'd0, out_comp, out_val};
  assign m_axis_tlast = out_last;

  `TBP_ASSERT(a_busy_nready, clk, rst, (state != tbpe_pkg::S_IDLE) |-> !s_axis_tready, "ready while busy")
  `TBP_ASSERT(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "output changed under stall")
  `TBP_ASSERT(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `TBP_ASSERT_RST(a_rst_idle, clk, $past(rst) |-> (state == tbpe_pkg::S_IDLE), "not idle after reset")
endmodule

>>> sim/tbpe_checker.sv
// result checker for the bezier patch evaluator: watches the input, config and
// result channels, predicts each point and compares it field by field
// depends on tbpe_pkg
`timescale 1ns / 100ps
module tbpe_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  output int          errors,
  output int          pending
);
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  comp;
    logic        last;
  } coord_t;

  logic [31:0] coeff_mem [tbpe_pkg::StoreDepth];
  logic [1:0]  dims_q;
  logic [2:0]  comps_q;
  logic [1:0]  deg_q [3];
  coord_t      coords_due [$];

  assign pending = coords_due.size();

  // one de casteljau step, floor division by one in Q1.16
  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] x);
    longint acc;
    acc = longint'(65536 - int'(x)) * longint'($signed(a)) + longint'(x) * longint'($signed(b));
    acc = acc >>> 16;
    return acc[31:0];
  endfunction

  task automatic predict_point(logic [95:0] d);
    int m, n, cnt, len, groups;
    int g [3];
    logic [16:0] x [3];
    logic [31:0] net [64];
    logic [31:0] row [4];
    coord_t c;
    m = dims_q;
    n = (comps_q == 0) ? 1 :
        (comps_q > tbpe_pkg::MaxComponents) ? tbpe_pkg::MaxComponents : comps_q;
    for (int i = 0; i < 3; i++) begin
      g[i] = deg_q[i];
      x[i] = d[40 + 17*i +: 17];
      if (x[i] > tbpe_pkg::OneQ16) x[i] = tbpe_pkg::OneQ16;
    end
    for (int j = 0; j < n; j++) begin
      cnt = 1;
      for (int i = 0; i < m; i++) cnt *= g[i] + 1;
      for (int i = 0; i < cnt; i++) net[i] = coeff_mem[(i*n + j) & 8'hff];
      // reduce the net one axis at a time, last axis first
      for (int a = m - 1; a >= 0; a--) begin
        len = g[a] + 1;
        groups = cnt / len;
        for (int q = 0; q < groups; q++) begin
          for (int s = 0; s < len; s++) row[s] = net[q*len + s];
          for (int r = g[a]; r > 0; r--)
            for (int s = 0; s < r; s++) row[s] = blend(row[s], row[s+1], x[a]);
          net[q] = row[0];
        end
        cnt = groups;
      end
      c.value = net[0];
      c.comp  = j[1:0];
      c.last  = (j + 1 == n);
      coords_due.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dims_q  <= 2'd1;
      comps_q <= 3'd1;
      for (int i = 0; i < 3; i++) deg_q[i] <= 2'd1;
      coords_due.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tbpe_pkg::RegDims:  dims_q   <= cfg_data[1:0];
          tbpe_pkg::RegComps: comps_q  <= cfg_data;
          tbpe_pkg::RegDeg0:  deg_q[0] <= cfg_data[1:0];
          tbpe_pkg::RegDeg1:  deg_q[1] <= cfg_data[1:0];
          tbpe_pkg::RegDeg2:  deg_q[2] <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == tbpe_pkg::FuncWrite) coeff_mem[s_axis_tdata[7:0]] = s_axis_tdata[39:8];
        else predict_point(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (coords_due.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          coord_t want;
          want = coords_due.pop_front();
          if (m_axis_tdata[31:0] !== want.value || m_axis_tdata[33:32] !== want.comp ||
              m_axis_tlast !== want.last) begin
            $display("%0t: point mismatch, expected value %h comp %0d last %0b, got %h %0d %0b",
                     $time, want.value, want.comp, want.last,
                     m_axis_tdata[31:0], m_axis_tdata[33:32], m_axis_tlast);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> sim/testbench.sv
// stimulus top for the bezier patch evaluator: coefficient writes, evaluations
// and register settings, with random idling on both streams
// depends on tbpe_pkg, tensor_bezier_patch_evaluator_unit and tbpe_checker
`timescale 1ns / 100ps
module testbench;
  localparam logic FuncEval   = ~tbpe_pkg::FuncWrite;
  localparam int   CycleLimit = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [2:0]  cfg_data = '0;
  int          errors, pending;

  // mirror of the settings, used only to keep evaluations on written entries
  int          dims_now = 1, comps_now = 1;
  int          deg_now [3] = '{1, 1, 1};
  bit          coeff_set [tbpe_pkg::StoreDepth];
  bit          calm = 1'b0;       // no idling on either side
  bit          hold_req = 1'b0;   // ask the receiver for one long hold-off
  int          cycles = 0;

  tensor_bezier_patch_evaluator_unit dut (.*);

  tbpe_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver side: random stall bursts plus one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one input transaction, then maybe a burst of idle cycles
  task automatic send_item(logic func, logic [7:0] idx, logic [31:0] val,
                           logic [16:0] x0, logic [16:0] x1, logic [16:0] x2);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {5'd0, x2, x1, x0, val, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (func == tbpe_pkg::FuncWrite) coeff_set[idx] = 1'b1;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic write_coeff(logic [7:0] idx, logic [31:0] val);
    send_item(tbpe_pkg::FuncWrite, idx, val, 17'($urandom), 17'($urandom), 17'($urandom));
  endtask

  // random parameter, mostly in range, sometimes above one to hit saturation
  function automatic logic [16:0] rand_param();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return tbpe_pkg::OneQ16;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // evaluation; first fills any coefficient the net would read unwritten
  task automatic evaluate(logic [16:0] x0, logic [16:0] x1, logic [16:0] x2);
    int n, span;
    n = (comps_now == 0) ? 1 :
        (comps_now > tbpe_pkg::MaxComponents) ? tbpe_pkg::MaxComponents : comps_now;
    span = n;
    for (int i = 0; i < dims_now; i++) span *= deg_now[i] + 1;
    for (int i = 0; i < span; i++)
      if (!coeff_set[i]) write_coeff(8'(i), $urandom);
    send_item(FuncEval, 8'($urandom), $urandom, x0, x1, x2);
  endtask

  // register writes only once the block has drained
  task automatic set_reg(logic [2:0] idx, logic [2:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tbpe_pkg::RegDims:  dims_now   = val[1:0];
      tbpe_pkg::RegComps: comps_now  = val;
      tbpe_pkg::RegDeg0:  deg_now[0] = val[1:0];
      tbpe_pkg::RegDeg1:  deg_now[1] = val[1:0];
      tbpe_pkg::RegDeg2:  deg_now[2] = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_patch(int dims, int comps, int d0, int d1, int d2);
    set_reg(tbpe_pkg::RegDims, 3'(dims));
    set_reg(tbpe_pkg::RegComps, 3'(comps));
    set_reg(tbpe_pkg::RegDeg0, 3'(d0));
    set_reg(tbpe_pkg::RegDeg1, 3'(d1));
    set_reg(tbpe_pkg::RegDeg2, 3'(d2));
  endtask

  // mixed random traffic: mostly evaluations, some coefficient rewrites
  task automatic random_traffic(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) write_coeff(8'($urandom), $urandom);
      else evaluate(rand_param(), rand_param(), rand_param());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: one axis of degree one, one component
    write_coeff(8'd0, 32'h8000_0000);
    write_coeff(8'd1, 32'h7fff_ffff);
    evaluate(17'd0, 17'd0, 17'd0);
    evaluate(tbpe_pkg::OneQ16, 17'd0, 17'd0);
    evaluate(17'h1ffff, 17'h1ffff, 17'h1ffff);   // above one saturates
    evaluate(17'd32768, 17'd1, 17'd65535);
    write_coeff(8'd0, 32'hffff_ffff);
    write_coeff(8'd1, 32'h0000_0001);
    evaluate(17'd1, 17'd0, 17'd0);
    evaluate(17'd65535, 17'd0, 17'd0);
    write_coeff(8'hff, 32'h1234_5678);

    // zero dimensions: the point is the first coefficients
    set_patch(0, 4, 3, 3, 3);
    evaluate(17'd100, 17'd200, 17'd300);
    // unknown register indexes are ignored
    set_reg(3'd5, 3'd7);
    set_reg(3'd6, 3'd0);
    set_reg(3'd7, 3'd3);
    evaluate(tbpe_pkg::OneQ16, 17'd0, 17'd0);

    // component count of zero acts as one, above four as four
    set_patch(1, 0, 3, 0, 0);
    evaluate(17'd40000, 17'd0, 17'd0);
    set_patch(2, 7, 0, 3, 0);
    evaluate(17'd12345, 17'd54321, 17'd0);

    // random phases over several patch shapes, extremes among them
    set_patch(1, 1, 1, 1, 1);
    random_traffic(10);
    set_patch(2, 2, 2, 1, 0);
    random_traffic(10);
    set_patch(3, 1, 1, 1, 1);
    random_traffic(10);

    // deepest net; long receiver hold-off so the block backs up
    set_patch(3, 1, 3, 3, 3);
    hold_req = 1'b1;
    random_traffic(6);
    set_patch(0, 3, 0, 0, 0);
    random_traffic(10);
    set_patch(2, 3, 3, 2, 1);
    random_traffic(10);
    set_patch(1, 5, 2, 3, 3);
    random_traffic(10);

    // last stretch with no idling at all
    set_patch(3, 2, 1, 2, 0);
    calm = 1'b1;
    random_traffic(20);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/tbpe_pkg.sv
rtl/tbpe_ram.sv
rtl/tensor_bezier_patch_evaluator_unit.sv
sim/tbpe_checker.sv
sim/testbench.sv
